// ===== hdl/stt_pkg.sv =====
// Shared types and constants for the software timer table.
package stt_pkg;

    localparam int SLOTS = 20;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int VAL_W = 8;
    localparam int SLOT_W = 5;
    localparam int HANDLE_W = 5;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_SCHED      = 2'd1,
        MODE_CANCEL     = 2'd2,
        MODE_CANCEL_ALL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_ACK   = 2'd0,
        ST_SCHED = 2'd1,
        ST_FIRED = 2'd2,
        ST_ERR   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ACK,
        EM_ERR,
        EM_SCHED,
        EM_FLUSH
    } t_emit;

    typedef struct packed {
        logic  idx_clr;
        logic  idx_inc;
        logic  tick_slot;
        logic  sched_slot;
        logic  cancel_one;
        logic  cancel_all;
        logic  latch_req;
        t_emit emit;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic slot_free;
        logic per_zero;
    } t_dp_stat;

endpackage

// ===== hdl/stt_ctrl.sv =====
// Sequencer for the timer table: decodes requests and steps the slot walk.
module stt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_mode,
    input  stt_pkg::t_dp_stat i_stat,
    output stt_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_SCHED,
        S_FLUSH
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy;
    t_dp_cmd n_cmd;

    always_comb begin
        n_cmd   = '0;
        n_cmd.emit = EM_NONE;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_TICK: begin
                            n_state = S_TICK;
                        end
                        MODE_SCHED: begin
                            if (i_stat.per_zero) begin
                                n_cmd.emit = EM_ERR;
                            end else begin
                                n_cmd.latch_req = 1'b1;
                                n_state = S_SCHED;
                            end
                        end
                        MODE_CANCEL: begin
                            n_cmd.cancel_one = 1'b1;
                            n_cmd.emit = EM_ACK;
                        end
                        MODE_CANCEL_ALL: begin
                            n_cmd.cancel_all = 1'b1;
                            n_cmd.emit = EM_ACK;
                        end
                        default: begin
                            n_cmd.emit = EM_ACK;
                        end
                    endcase
                end
            end
            S_TICK: begin
                n_cmd.tick_slot = 1'b1;
                if (i_stat.idx_last) begin
                    n_cmd.idx_clr = 1'b1;
                    n_state = S_FLUSH;
                end else begin
                    n_cmd.idx_inc = 1'b1;
                end
            end
            S_FLUSH: begin
                n_cmd.emit = EM_FLUSH;
                n_state = S_IDLE;
            end
            S_SCHED: begin
                if (i_stat.slot_free) begin
                    n_cmd.sched_slot = 1'b1;
                    n_cmd.emit = EM_SCHED;
                    n_cmd.idx_clr = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.idx_last) begin
                    n_cmd.emit = EM_ERR;
                    n_cmd.idx_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd = n_cmd;
    assign busy  = r_busy;

endmodule

// ===== hdl/stt_dp.sv =====
// Slot stores, walk index, held firing and result register.
module stt_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stt_pkg::t_dp_cmd                  i_cmd,
    input  logic [stt_pkg::VAL_W-1:0]         i_period,
    input  logic [stt_pkg::VAL_W-1:0]         i_repeat_count,
    input  logic [stt_pkg::HANDLE_W-1:0]      i_handle,
    output stt_pkg::t_dp_stat                 o_stat,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [stt_pkg::SLOT_W-1:0]        o_slot,
    output logic                              o_last
);
    import stt_pkg::*;

    logic [VAL_W-1:0] r_per [SLOTS];
    logic [VAL_W-1:0] r_cd  [SLOTS];
    logic [VAL_W-1:0] r_rep [SLOTS];
    logic [SLOTS-1:0] r_active;

    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_per_l, r_rep_l;
    logic             r_pend_vld;
    logic [IDX_W-1:0] r_pend_slot;

    logic             r_out_vld, n_out_vld;
    t_status          r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic             r_last, n_last;

    logic [VAL_W-1:0] cur_per, cur_cd, cur_rep, rep_m1;
    logic             cur_act, fire, handle_ok;

    assign cur_per = r_per[r_idx];
    assign cur_cd  = r_cd[r_idx];
    assign cur_rep = r_rep[r_idx];
    assign cur_act = r_active[r_idx];
    assign rep_m1  = cur_rep - VAL_W'(1);
    assign fire    = cur_act && (cur_cd == '0);
    assign handle_ok = (int'(i_handle) < SLOTS);

    assign o_stat.idx_last  = (int'(r_idx) == SLOTS - 1);
    assign o_stat.slot_free = !cur_act;
    assign o_stat.per_zero  = (i_period == '0);

    // slot stores: only read where the active bit is set
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_per_l <= i_period;
            r_rep_l <= i_repeat_count;
        end
        if (i_cmd.sched_slot) begin
            r_per[r_idx] <= r_per_l;
            r_cd[r_idx]  <= r_per_l;
            r_rep[r_idx] <= r_rep_l;
        end else if (i_cmd.tick_slot && cur_act) begin
            if (fire) begin
                if (cur_rep != '0) begin
                    r_rep[r_idx] <= rep_m1;
                end
                r_cd[r_idx] <= cur_per;
            end else begin
                r_cd[r_idx] <= cur_cd - VAL_W'(1);
            end
        end
        if (i_cmd.tick_slot && fire) begin
            r_pend_slot <= r_idx;
        end
    end

    always_comb begin
        n_out_vld = 1'b0;
        n_status  = ST_ACK;
        n_slot    = '0;
        n_last    = 1'b1;
        case (i_cmd.emit)
            EM_ACK: begin
                n_out_vld = 1'b1;
            end
            EM_ERR: begin
                n_out_vld = 1'b1;
                n_status  = ST_ERR;
            end
            EM_SCHED: begin
                n_out_vld = 1'b1;
                n_status  = ST_SCHED;
                n_slot    = SLOT_W'(r_idx);
            end
            EM_FLUSH: begin
                n_out_vld = 1'b1;
                if (r_pend_vld) begin
                    n_status = ST_FIRED;
                    n_slot   = SLOT_W'(r_pend_slot);
                end
            end
            default: begin
                // a new firing pushes out the held one, not yet the final
                if (i_cmd.tick_slot && fire && r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_status  = ST_FIRED;
                    n_slot    = SLOT_W'(r_pend_slot);
                    n_last    = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.cancel_all) begin
                r_active <= '0;
            end else if (i_cmd.cancel_one && handle_ok) begin
                r_active[IDX_W'(i_handle)] <= 1'b0;
            end else if (i_cmd.sched_slot) begin
                r_active[r_idx] <= 1'b1;
            end else if (i_cmd.tick_slot && fire && cur_rep != '0 && rep_m1 == '0) begin
                r_active[r_idx] <= 1'b0;
            end

            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end

            if (i_cmd.emit == EM_FLUSH) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.tick_slot && fire) begin
                r_pend_vld <= 1'b1;
            end

            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_last   <= n_last;
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_last   = r_last;

endmodule

// ===== hdl/software_timer_table.sv =====
// Top level of the software timer table: sequencer plus slot datapath.
// Tick: walks all SLOTS slots one per cycle, then flushes, busy until the flush ends;
//   one firing result per fired slot (final one marked last), or an ack if none fires.
// Schedule: searches slots one per cycle until a free slot or the last; zero period and
//   cancels answer without going busy. Results show the cycle after they are decided.
// Reset (synchronous, active low) frees every slot at once; results cannot be stalled.
module software_timer_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [stt_pkg::VAL_W-1:0]     i_period,
    input  logic [stt_pkg::VAL_W-1:0]     i_repeat_count,
    input  logic [stt_pkg::HANDLE_W-1:0]  i_handle,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [stt_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_last
);
    import stt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer: accepts a transfer only while idle and steps the walk.
    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath: slot stores, walk index, one held firing so that the
    // final firing of a tick can carry the last mark.
    stt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_period       (i_period),
        .i_repeat_count (i_repeat_count),
        .i_handle       (i_handle),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

endmodule

// ===== sim/software_timer_table_test.sv =====
`timescale 1ns / 100ps
// Testbench for the software timer table: request driver, timer scoreboard and result checks.

import stt_pkg::*;

// One result transfer as the table should present it.
typedef struct {
    t_status              status;
    logic [SLOT_W-1:0]    slot;
    logic                 is_last;
} t_timer_result;

// Mirrors the slot table and queues the results each accepted request must produce.
class timer_table_board;
    logic [VAL_W-1:0] period_mem[SLOTS];   // zero period marks a free slot
    logic [VAL_W-1:0] count_mem[SLOTS];
    logic [VAL_W-1:0] reps_mem[SLOTS];     // zero repeats means the timer runs forever
    t_timer_result    due_results[$];
    int               mismatches;
    int               printed;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            period_mem[i] = '0;
            count_mem[i]  = '0;
            reps_mem[i]   = '0;
        end
        mismatches = 0;
        printed    = 0;
    endfunction

    function void add_due(t_status status, int slot, logic is_last);
        t_timer_result r;
        r.status  = status;
        r.slot    = SLOT_W'(slot);
        r.is_last = is_last;
        due_results.push_back(r);
    endfunction

    // Applies one accepted request to the mirrored table and queues its results.
    function void note_request(t_mode mode, logic [VAL_W-1:0] per, logic [VAL_W-1:0] reps,
                               logic [HANDLE_W-1:0] handle);
        int fired;
        int free_slot;
        fired     = 0;
        free_slot = -1;
        case (mode)
            MODE_TICK: begin
                // ascending walk: zero countdown fires and reloads, others count down
                for (int i = 0; i < SLOTS; i++) begin
                    if (period_mem[i] == '0) continue;
                    if (count_mem[i] == '0) begin
                        add_due(ST_FIRED, i, 1'b0);
                        fired++;
                        if (reps_mem[i] != '0) begin
                            reps_mem[i] = reps_mem[i] - 1'b1;
                            if (reps_mem[i] == '0) begin
                                period_mem[i] = '0;   // last repeat frees the slot
                                continue;
                            end
                        end
                        count_mem[i] = period_mem[i];
                    end else begin
                        count_mem[i] = count_mem[i] - 1'b1;
                    end
                end
                if (fired == 0) add_due(ST_ACK, 0, 1'b1);
                else due_results[due_results.size() - 1].is_last = 1'b1;
            end
            MODE_SCHED: begin
                if (per != '0) begin
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (period_mem[i] == '0) free_slot = i;
                    end
                end
                if (free_slot < 0) begin
                    add_due(ST_ERR, 0, 1'b1);       // zero period or table full
                end else begin
                    period_mem[free_slot] = per;
                    count_mem[free_slot]  = per;
                    reps_mem[free_slot]   = reps;
                    add_due(ST_SCHED, free_slot, 1'b1);
                end
            end
            MODE_CANCEL: begin
                if (handle < SLOTS) period_mem[handle] = '0;
                add_due(ST_ACK, 0, 1'b1);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) period_mem[i] = '0;
                add_due(ST_ACK, 0, 1'b1);
            end
        endcase
    endfunction

    task report(string what);
        mismatches++;
        if (printed < 40) begin
            $display("%0t mismatch: %s", $time, what);
            printed++;
        end
    endtask

    task check_result(logic [1:0] status, logic [SLOT_W-1:0] slot, logic is_last);
        t_timer_result want;
        if (due_results.size() == 0) begin
            report($sformatf("unexpected result status %0d slot %0d last %0d",
                             status, slot, is_last));
            return;
        end
        want = due_results.pop_front();
        if (status !== want.status || slot !== want.slot || is_last !== want.is_last)
            report($sformatf("got status %0d slot %0d last %0d, want status %0d slot %0d last %0d",
                             status, slot, is_last, want.status, want.slot, want.is_last));
    endtask
endclass

module software_timer_table_test;

    // long enough for a whole tick walk and its flush, plus the output register
    localparam int FLUSH_CYCLES = SLOTS + 8;
    localparam int DRAIN_LIMIT  = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_mode;
    logic [VAL_W-1:0]     i_period;
    logic [VAL_W-1:0]     i_repeat_count;
    logic [HANDLE_W-1:0]  i_handle;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_last;

    timer_table_board board;
    int               burst_left;   // transfers left in a back-to-back stretch

    software_timer_table u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_period       (i_period),
        .i_repeat_count (i_repeat_count),
        .i_handle       (i_handle),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the table hangs; far beyond the slowest correct run.
    initial begin
        #400000;
        $display("[software_timer_table] ERROR");
        $finish;
    end

    // Results cannot be held off: every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_status, o_slot, o_last);
    end

    // One request transfer. Inputs move on the falling edge; while idle the fields
    // carry noise that the table has to ignore. start stays high across back-to-back
    // transfers, since it is assigned only once per falling edge.
    task automatic send_request(t_mode mode, logic [VAL_W-1:0] per, logic [VAL_W-1:0] reps,
                                logic [HANDLE_W-1:0] handle);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(4, 20);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            start          = 1'b0;
            i_mode         = 2'($urandom_range(0, 3));
            i_period       = VAL_W'($urandom());
            i_repeat_count = VAL_W'($urandom());
            i_handle       = HANDLE_W'($urandom());
            repeat (gap) @(negedge i_clk);
        end
        start          = 1'b1;
        i_mode         = mode;
        i_period       = per;
        i_repeat_count = reps;
        i_handle       = handle;
        do @(posedge i_clk); while (busy);
        board.note_request(mode, per, reps, handle);
    endtask

    // Sender holds off until every queued result has come back (bounded).
    task automatic wait_for_results(int limit);
        int waited;
        waited = 0;
        @(negedge i_clk);
        start = 1'b0;
        while (board.due_results.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Mostly short periods and few repeats so timers fire and free slots often;
    // now and then full-range values, zero periods and out-of-range handles.
    task automatic send_random_request();
        int                  pick;
        t_mode               mode;
        logic [VAL_W-1:0]    per;
        logic [VAL_W-1:0]    reps;
        logic [HANDLE_W-1:0] handle;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       per = '0;
            1, 2:    per = VAL_W'($urandom_range(1, 255));
            default: per = VAL_W'($urandom_range(1, 4));
        endcase
        reps   = ($urandom_range(0, 4) == 0) ? VAL_W'($urandom())
                                             : VAL_W'($urandom_range(0, 3));
        handle = ($urandom_range(0, 4) == 0) ? HANDLE_W'($urandom())
                                             : HANDLE_W'($urandom_range(0, SLOTS - 1));
        if (pick < 45)      mode = MODE_TICK;
        else if (pick < 80) mode = MODE_SCHED;
        else if (pick < 96) mode = MODE_CANCEL;
        else                mode = MODE_CANCEL_ALL;
        send_request(mode, per, reps, handle);
    endtask

    initial begin
        board          = new();
        burst_left     = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_mode         = MODE_TICK;
        i_period       = '0;
        i_repeat_count = '0;
        i_handle       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part
        send_request(MODE_TICK, '0, '0, '0);              // empty table: lone acknowledge
        send_request(MODE_SCHED, 8'd0, 8'd5, '0);         // zero period rejected, no slot taken
        send_request(MODE_SCHED, 8'd1, 8'd1, '0);         // slot 0, one shot
        send_request(MODE_SCHED, 8'd255, 8'd255, '0);     // slot 1, widest values
        send_request(MODE_SCHED, 8'd1, 8'd0, '0);         // slot 2, runs forever
        send_request(MODE_SCHED, 8'd2, 8'd3, 5'h1f);      // slot 3, three firings
        repeat (4) send_request(MODE_TICK, 8'hff, 8'hff, 5'h1f);
        send_request(MODE_SCHED, 8'd3, 8'd2, '0);         // reuses the freed slot 0
        send_request(MODE_CANCEL, '0, '0, 5'd1);          // cancel an active slot
        send_request(MODE_CANCEL, '0, '0, 5'd31);         // handle out of range
        send_request(MODE_CANCEL, '0, '0, 5'd20);         // first handle past the table
        send_request(MODE_CANCEL, '0, '0, 5'd19);         // cancel a free slot
        repeat (3) send_request(MODE_TICK, '0, '0, '0);
        send_request(MODE_CANCEL_ALL, 8'hff, 8'hff, 5'h1f);
        send_request(MODE_TICK, '0, '0, '0);
        wait_for_results(DRAIN_LIMIT);

        // Random part. Odd phases first push the table past full with short
        // timers, so the following ticks fire many slots in one sweep.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 2 == 1) begin
                for (int k = 0; k < SLOTS + 2; k++)
                    send_request(MODE_SCHED, VAL_W'($urandom_range(1, 3)),
                                 VAL_W'($urandom_range(0, 2)), HANDLE_W'($urandom()));
            end
            repeat (40) send_random_request();
            if (phase == 2) wait_for_results(DRAIN_LIMIT);
        end

        wait_for_results(DRAIN_LIMIT);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (board.due_results.size() != 0)
            board.report($sformatf("%0d expected results never arrived",
                                   board.due_results.size()));
        if (board.mismatches == 0) begin
            $display("[software_timer_table] OK");
        end else begin
            $display("[software_timer_table] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/stt_pkg.sv
hdl/stt_ctrl.sv
hdl/stt_dp.sv
hdl/software_timer_table.sv
sim/software_timer_table_test.sv
